>>> rtl/core/mhe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mhe_pkg;

	localparam int DEPTH = 64;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int KW    = 32;

	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	localparam logic [2:0] KIND_LOAD   = 3'd0;
	localparam logic [2:0] KIND_BUILD  = 3'd1;
	localparam logic [2:0] KIND_DELMIN = 3'd2;
	localparam logic [2:0] KIND_DELIDX = 3'd3;
	localparam logic [2:0] KIND_READ   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] waddr;
		logic [KW-1:0] wdata;
		logic [AW-1:0] raddr;
	} mem_req_t;

endpackage
`default_nettype wire

>>> rtl/core/mhe_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module mhe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a same-address write shows up on the next read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/core/mhe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mhe_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [2:0]                kind,
	input  wire logic [mhe_pkg::KW-1:0]    key_in,
	input  wire logic [mhe_pkg::AW-1:0]    slot,
	output logic                           busy,
	output logic                           done,
	output logic      [mhe_pkg::KW-1:0]    key_out,
	output logic      [mhe_pkg::CW-1:0]    count,
	output logic      [1:0]                status,
	output mhe_pkg::mem_req_t              mem_req,
	input  wire logic [mhe_pkg::KW-1:0]    rd_data
);

	localparam int AW = mhe_pkg::AW;
	localparam int CW = mhe_pkg::CW;
	localparam int KW = mhe_pkg::KW;
	localparam int IW = AW + 2;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_DKEY = 4'd2;
	localparam logic [3:0] S_UP   = 4'd3;
	localparam logic [3:0] S_RM   = 4'd4;
	localparam logic [3:0] S_BKEY = 4'd5;
	localparam logic [3:0] S_SCHK = 4'd6;
	localparam logic [3:0] S_SL   = 4'd7;
	localparam logic [3:0] S_SR   = 4'd8;

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [AW-1:0] pos_q, pos_d;
	logic [AW-1:0] bld_q, bld_d;
	logic          build_q, build_d;
	logic [KW-1:0] key_q, key_d;
	logic [KW-1:0] lkey_q, lkey_d;
	logic [KW-1:0] okey_q, okey_d;
	logic [1:0]    ostat_q, ostat_d;
	logic          done_q, done_d;
	logic          fwd_hit_q;
	logic [KW-1:0] fwd_q;

	logic [KW-1:0] rd;
	logic [IW-1:0] l_w, r_w, n_w;
	logic          l_in, r_in;
	logic [AW-1:0] l_a, r_a, last_a, par_a, half_a;
	logic          sel_right, move, sift_end;
	logic [AW-1:0] pick_a;
	logic [KW-1:0] pick_v;

	function automatic logic key_less(input logic [KW-1:0] a, input logic [KW-1:0] b);
		return $signed(a) < $signed(b);
	endfunction

	// bypass a write that lands on the address read in the same cycle
	assign rd = fwd_hit_q ? fwd_q : rd_data;

	assign l_w    = {1'b0, pos_q, 1'b1};
	assign r_w    = l_w + 1'b1;
	assign n_w    = IW'(cnt_q);
	assign l_in   = l_w < n_w;
	assign r_in   = r_w < n_w;
	assign l_a    = l_w[AW-1:0];
	assign r_a    = r_w[AW-1:0];
	assign last_a = AW'(cnt_q - 1'b1);
	assign par_a  = AW'((pos_q - 1'b1) >> 1);
	assign half_a = AW'((cnt_q >> 1) - 1'b1);

	// ties between children go right
	assign sel_right = (state_q == S_SR) && !key_less(lkey_q, rd);
	assign pick_a    = sel_right ? r_a : l_a;
	assign pick_v    = ((state_q == S_SR) && !sel_right) ? lkey_q : rd;
	assign move      = key_less(pick_v, key_q);

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		pos_d    = pos_q;
		bld_d    = bld_q;
		build_d  = build_q;
		key_d    = key_q;
		lkey_d   = lkey_q;
		okey_d   = okey_q;
		ostat_d  = ostat_q;
		done_d   = 1'b0;
		sift_end = 1'b0;
		mem_req  = '0;

		unique case (state_q) inside
			S_IDLE: begin
				if (start) begin
					okey_d  = '0;
					ostat_d = mhe_pkg::ST_OK;
					case (kind) inside
						mhe_pkg::KIND_LOAD: begin
							done_d = 1'b1;
							if (cnt_q == mhe_pkg::FULL_CNT) begin
								ostat_d = mhe_pkg::ST_FULL;
							end else begin
								mem_req.we    = 1'b1;
								mem_req.waddr = AW'(cnt_q);
								mem_req.wdata = key_in;
								cnt_d         = cnt_q + 1'b1;
							end
						end
						mhe_pkg::KIND_BUILD: begin
							if (cnt_q < CW'(2)) begin
								done_d = 1'b1;
							end else begin
								bld_d         = half_a;
								build_d       = 1'b1;
								mem_req.raddr = half_a;
								state_d       = S_BKEY;
							end
						end
						mhe_pkg::KIND_DELMIN, mhe_pkg::KIND_DELIDX: begin
							if (cnt_q == '0) begin
								ostat_d = mhe_pkg::ST_EMPTY;
								done_d  = 1'b1;
							end else if (kind == mhe_pkg::KIND_DELIDX &&
							             CW'(slot) >= cnt_q) begin
								ostat_d = mhe_pkg::ST_RANGE;
								done_d  = 1'b1;
							end else begin
								pos_d         = (kind == mhe_pkg::KIND_DELMIN) ? '0 : slot;
								mem_req.raddr = pos_d;
								build_d       = 1'b0;
								state_d       = S_DKEY;
							end
						end
						mhe_pkg::KIND_READ: begin
							if (cnt_q == '0) begin
								ostat_d = mhe_pkg::ST_EMPTY;
								done_d  = 1'b1;
							end else if (CW'(slot) >= cnt_q) begin
								ostat_d = mhe_pkg::ST_RANGE;
								done_d  = 1'b1;
							end else begin
								mem_req.raddr = slot;
								state_d       = S_RD;
							end
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_RD: begin
				okey_d  = rd;
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
			S_DKEY: begin
				okey_d = rd;
				if (pos_q == '0) begin
					mem_req.raddr = last_a;
					state_d       = S_RM;
				end else begin
					mem_req.raddr = par_a;
					state_d       = S_UP;
				end
			end
			S_UP: begin
				// ancestors slide down one level toward the removed slot
				mem_req.we    = 1'b1;
				mem_req.waddr = pos_q;
				mem_req.wdata = rd;
				pos_d         = par_a;
				if (par_a == '0) begin
					mem_req.raddr = last_a;
					state_d       = S_RM;
				end else begin
					mem_req.raddr = AW'((par_a - 1'b1) >> 1);
					state_d       = S_UP;
				end
			end
			S_RM: begin
				key_d   = rd;
				cnt_d   = cnt_q - 1'b1;
				pos_d   = '0;
				state_d = S_SCHK;
			end
			S_BKEY: begin
				key_d   = rd;
				pos_d   = bld_q;
				state_d = S_SCHK;
			end
			S_SCHK: begin
				if (l_in) begin
					mem_req.raddr = l_a;
					state_d       = S_SL;
				end else begin
					sift_end = 1'b1;
				end
			end
			S_SL, S_SR: begin
				if (state_q == S_SL) begin
					lkey_d = rd;
				end
				if (state_q == S_SL && r_in) begin
					mem_req.raddr = r_a;
					state_d       = S_SR;
				end else if (move) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = pos_q;
					mem_req.wdata = pick_v;
					pos_d         = pick_a;
					state_d       = S_SCHK;
				end else begin
					sift_end = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// the sifted key is written once, where it comes to rest
		if (sift_end) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = pos_q;
			mem_req.wdata = key_q;
			if (build_q && bld_q != '0) begin
				bld_d         = bld_q - 1'b1;
				mem_req.raddr = bld_q - 1'b1;
				state_d       = S_BKEY;
			end else begin
				done_d  = 1'b1;
				state_d = S_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			build_q   <= 1'b0;
			done_q    <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			build_q   <= build_d;
			done_q    <= done_d;
			fwd_hit_q <= mem_req.we && (mem_req.waddr == mem_req.raddr);
		end
	end

	always_ff @(posedge clk) begin
		pos_q   <= pos_d;
		bld_q   <= bld_d;
		key_q   <= key_d;
		lkey_q  <= lkey_d;
		okey_q  <= okey_d;
		ostat_q <= ostat_d;
		fwd_q   <= mem_req.wdata;
	end

	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign key_out = okey_q;
	assign count   = cnt_q;
	assign status  = ostat_q;

endmodule
`default_nettype wire

>>> rtl/core/min_heap_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Binary min-heap of signed 32-bit keys held in one 64-entry synchronous RAM.
// A request is taken when start is high and busy is low; its single result
// is shown for exactly one cycle with done high, and the receiver cannot
// stall it. Work is a walk through the one-read-port RAM: load, error cases
// and unused kinds finish without a walk, and read fetches one slot. Delete
// reads the chosen entry, moves each of its ancestors down one level, moves
// the last entry to the root and sifts it down. Build runs one sift per
// parent from count/2-1 down to the root. busy stays high for the whole walk;
// the next request can be issued in the cycle that done is shown. The count
// port always shows the current number of entries.
module min_heap_engine_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire logic [2:0]                kind,
	input  wire logic [mhe_pkg::KW-1:0]    key_in,
	input  wire logic [mhe_pkg::AW-1:0]    slot,
	output logic                           done,
	output logic      [mhe_pkg::KW-1:0]    key_out,
	output logic      [mhe_pkg::CW-1:0]    count,
	output logic      [1:0]                status
);

	mhe_pkg::mem_req_t          mem_req;
	logic [mhe_pkg::KW-1:0]     rd_data;

	mhe_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.kind    (kind),
		.key_in  (key_in),
		.slot    (slot),
		.busy    (busy),
		.done    (done),
		.key_out (key_out),
		.count   (count),
		.status  (status),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	mhe_ram #(
		.WIDTH (mhe_pkg::KW),
		.DEPTH (mhe_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (rd_data)
	);

	// a result always comes with the engine back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// errors report a zero key
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != mhe_pkg::ST_OK) |-> (key_out == '0))
		else $error("nonzero key on error result");

	// a load into a store with room grows the count by one and finishes at once
	a_load_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == mhe_pkg::KIND_LOAD && count != mhe_pkg::FULL_CNT)
		|=> (done && !busy && count == $past(count) + 1'b1))
		else $error("load did not append");

	// a valid read stays busy for the RAM read, then shows done with the engine idle
	a_read_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind == mhe_pkg::KIND_READ && count != '0 &&
		 mhe_pkg::CW'(slot) < count) |=> (busy && !done) ##1 (done && !busy))
		else $error("read latency broken");

endmodule
`default_nettype wire
